// File: sv/assert_macros.svh
// Assertion macros shared by the trimmed-mean filter RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, disabled while reset is asserted
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, live during reset as well
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALL(lbl, clk, prop, msg)
`endif
`endif

// File: sv/stm_pkg.sv
// Types, codes and constants of the sliding trimmed-mean filter.
// No dependencies; imported by the interfaces and all modules.
package stm_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CNT_W    = 4;
  // Largest middle sum: eight full-scale samples
  localparam int unsigned SUM_W    = 15;

  // Number of items accepted before means are produced
  localparam logic [CNT_W-1:0] WARMUP_ITEMS = CNT_W'(13);

  // floor(x / 3) == (x * DIV3_RECIP) >> DIV3_SHIFT for x below 2**17
  localparam logic [15:0] DIV3_RECIP = 16'd43691;
  localparam int unsigned DIV3_SHIFT = 17;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Trim mode register codes; the spare code behaves as TRIM_SIX
  typedef enum logic [1:0] {
    TRIM_SIX   = 2'd0,
    TRIM_EIGHT = 2'd1,
    TRIM_FOUR  = 2'd2
  } stm_trim_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_SUM,
    S_EMIT
  } stm_state_e;

  // Command broadcast to every cell of the sorted row
  typedef struct packed {
    logic    del_en;
    logic    ins_en;
    sample_t del_val;
    sample_t ins_val;
  } stm_sort_op_t;

endpackage

// File: sv/stm_sample_if.sv
// Input sample channel: valid/ready handshake with one 12-bit sample per beat.
// Depends on stm_pkg.
interface stm_sample_if;
  import stm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: sv/stm_result_if.sv
// Result channel: valid/ready handshake carrying the filtered value and warm flag.
// Depends on stm_pkg.
interface stm_result_if;
  import stm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t filtered;
  logic    warmed_up;

  modport source (output valid, output filtered, output warmed_up, input ready);
  modport sink   (input valid, input filtered, input warmed_up, output ready);
endinterface

// File: sv/stm_cfg_if.sv
// Configuration write channel for the trim mode register.
// Depends on stm_pkg.
interface stm_cfg_if;
  import stm_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] trim_mode;

  modport source (output valid, output trim_mode, input ready);
  modport sink   (input valid, input trim_mode, output ready);
endinterface

// File: sv/sliding_trimmed_mean_filter_core.sv
// Sliding trimmed-mean filter: sample ring, sorted cell row, mean unit.
// Depends on stm_pkg, the three channel interfaces, stm_cell, stm_mean
// and assert_macros.svh.
//
// Usage:
//   sample_i takes one 12-bit converter sample per beat; result_o gives one
//   beat per sample with the filtered value and the warmed_up flag; cfg_i
//   writes the 2-bit trim mode (always ready) and is meant for idle periods.
//   The first 13 samples enter the ring and give filtered = 0, warmed_up = 0.
//   Afterwards a zero sample is replaced by the value in the oldest ring slot,
//   which enters the window again.
// Timing:
//   A sample accepted in the idle state passes through the insert, sum and
//   emit steps before it shows on result_o, and no new sample is taken until
//   the sequencer is back in idle. The sequence is set by the sorted cell row,
//   which removes the leaving sample on the accepting edge and inserts the new
//   one on the next, followed by the span sum and the divide-and-register step.
//   If result_o is stalled the finished value waits in the output register;
//   the following sample is processed and holds in its last step until the
//   output register is free.
// Reset:
//   rst_ni clears the ring, the sorted row, the warm-up counter, the trim mode and
//   the output valid flag at once; no clearing pass is needed.
module sliding_trimmed_mean_filter_core #(
  parameter int unsigned RING_DEPTH = 14,
  parameter int unsigned WINDOW     = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  stm_sample_if.sink          sample_i,
  stm_cfg_if.sink             cfg_i,
  stm_result_if.source        result_o
);
  import stm_pkg::*;
  `include "assert_macros.svh"

  stm_state_e       state_q, state_d;
  logic [1:0]       trim_q;
  logic [CNT_W-1:0] warm_cnt_q;
  sample_t          ring_q [RING_DEPTH];
  sample_t          enter_val, enter_q;
  logic             item_warm_q;
  logic             warm, in_beat, out_load;
  logic             insert_en, sum_en;
  stm_sort_op_t     sort_op;
  sample_t          sorted [WINDOW];
  sample_t          mean;
  logic             out_valid_q;
  sample_t          filtered_q;
  logic             warmed_q;
  logic             sorted_ok;

  // Configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q <= TRIM_SIX;
    end else if (cfg_i.valid) begin
      trim_q <= cfg_i.trim_mode;
    end
  end

  // Sample intake: after warm-up a zero sample recirculates the oldest slot
  assign warm      = (warm_cnt_q == WARMUP_ITEMS);
  assign in_beat   = sample_i.valid && sample_i.ready;
  assign enter_val = (warm && (sample_i.sample == '0)) ? ring_q[RING_DEPTH-1]
                                                       : sample_i.sample;

  // Ring as a shift line, newest in slot 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring_q[k] <= '0;
      end
      warm_cnt_q <= '0;
    end else if (in_beat) begin
      ring_q[0] <= enter_val;
      for (int k = 1; k < RING_DEPTH; k++) begin
        ring_q[k] <= ring_q[k-1];
      end
      if (!warm) begin
        warm_cnt_q <= warm_cnt_q + CNT_W'(1);
      end
    end
  end

  // Hold the entering value and the warm flag for the later steps
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      enter_q     <= enter_val;
      item_warm_q <= warm;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_beat) state_d = S_INSERT;
      S_INSERT: state_d = S_SUM;
      S_SUM:    state_d = S_EMIT;
      S_EMIT:   if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    sample_i.ready = 1'b0;
    insert_en      = 1'b0;
    sum_en         = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      S_IDLE:   sample_i.ready = 1'b1;
      S_INSERT: insert_en = 1'b1;
      S_SUM:    sum_en = 1'b1;
      S_EMIT:   out_load = !out_valid_q || result_o.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sorted row: drop the sample leaving the window, then insert the new one
  assign sort_op.del_en  = in_beat;
  assign sort_op.ins_en  = insert_en;
  assign sort_op.del_val = ring_q[WINDOW-1];
  assign sort_op.ins_val = enter_q;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    sample_t left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = sorted[i-1];
    end
    if (i == WINDOW - 1) begin : g_last
      assign right_v = sorted[i];
    end else begin : g_right
      assign right_v = sorted[i+1];
    end
    stm_cell #(
      .IS_FIRST (i == 0),
      .IS_LAST  (i == WINDOW - 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (sort_op),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (sorted[i])
    );
  end

  stm_mean #(
    .WINDOW (WINDOW)
  ) u_mean (
    .clk_i    (clk_i),
    .sum_en_i (sum_en),
    .mode_i   (trim_q),
    .sorted_i (sorted),
    .mean_o   (mean)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filtered_q <= item_warm_q ? mean : '0;
      warmed_q   <= item_warm_q;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.filtered  = filtered_q;
  assign result_o.warmed_up = warmed_q;

  // Row order check between items
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 1; i < WINDOW; i++) begin
      if (sorted[i-1] > sorted[i]) begin
        sorted_ok = 1'b0;
      end
    end
  end

  `ASSERT_RST(a_beat_starts_insert, clk_i, rst_ni, in_beat |=> (state_q == S_INSERT), "accepted beat did not start insert")
  `ASSERT_RST(a_row_sorted, clk_i, rst_ni, (state_q == S_IDLE) |-> sorted_ok, "sorted row out of order")
  `ASSERT_RST(a_warmup_zero, clk_i, rst_ni, (out_load && !item_warm_q) |=> ((result_o.filtered == '0) && !result_o.warmed_up), "warm-up result not zero")
  `ASSERT_ALL(a_warm_cnt_max, clk_i, (warm_cnt_q <= WARMUP_ITEMS), "warm-up count past limit")

endmodule

// File: sv/stm_cell.sv
// One cell of the sorted window row: holds one sorted sample and shifts it
// towards or away from its neighbours on delete and insert. Depends on stm_pkg.
module stm_cell #(
  parameter bit IS_FIRST = 1'b0,
  parameter bit IS_LAST  = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stm_pkg::stm_sort_op_t op_i,
  input  stm_pkg::sample_t     left_i,
  input  stm_pkg::sample_t     right_i,
  output stm_pkg::sample_t     value_o
);
  import stm_pkg::*;

  sample_t value_q, value_d;

  // Delete: every cell at or past the leaving value takes its right neighbour.
  // Insert: cells below the new value hold (the last cell excepted), the first cell
  // not below it takes the new value, the rest take their left neighbour.
  always_comb begin
    value_d = value_q;
    if (op_i.del_en) begin
      if (value_q >= op_i.del_val) begin
        value_d = right_i;
      end
    end else if (op_i.ins_en) begin
      if (!IS_LAST && (value_q < op_i.ins_val)) begin
        value_d = value_q;
      end else if (IS_FIRST || (left_i < op_i.ins_val)) begin
        value_d = op_i.ins_val;
      end else begin
        value_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

// File: sv/stm_mean.sv
// Middle-span sum and truncated mean over the sorted window row.
// Depends on stm_pkg.
module stm_mean #(
  parameter int unsigned WINDOW = 12
) (
  input  logic             clk_i,
  input  logic             sum_en_i,
  input  logic [1:0]       mode_i,
  input  stm_pkg::sample_t sorted_i [WINDOW],
  output stm_pkg::sample_t mean_o
);
  import stm_pkg::*;

  localparam int unsigned START8 = (WINDOW - 8) / 2;
  localparam int unsigned START6 = (WINDOW - 6) / 2;
  localparam int unsigned START4 = (WINDOW - 4) / 2;

  sample_t              term [8];
  logic [SUM_W-1:0]     sum_d, sum_q;
  logic [SUM_W-2:0]     half;
  logic [SUM_W+14:0]    prod;

  // Pick the middle values for the selected span, zero beyond its count
  for (genvar k = 0; k < 8; k++) begin : g_term
    sample_t t8, t6, t4;
    assign t8 = sorted_i[START8+k];
    if (k < 6) begin : g_six
      assign t6 = sorted_i[START6+k];
    end else begin : g_six_pad
      assign t6 = '0;
    end
    if (k < 4) begin : g_four
      assign t4 = sorted_i[START4+k];
    end else begin : g_four_pad
      assign t4 = '0;
    end
    always_comb begin
      case (mode_i)
        TRIM_EIGHT: term[k] = t8;
        TRIM_FOUR:  term[k] = t4;
        default:    term[k] = t6;
      endcase
    end
  end

  // Add up the span
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 8; k++) begin
      sum_d = sum_d + SUM_W'(term[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      sum_q <= sum_d;
    end
  end

  // Divide: shifts for eight and four, halve then reciprocal for six
  assign half = sum_q[SUM_W-1:1];
  assign prod = (SUM_W+15)'(half) * (SUM_W+15)'(DIV3_RECIP);

  always_comb begin
    case (mode_i)
      TRIM_EIGHT: mean_o = sum_q[SUM_W-1:3];
      TRIM_FOUR:  mean_o = sum_q[SUM_W-2:2];
      default:    mean_o = prod[DIV3_SHIFT+SAMPLE_W-1:DIV3_SHIFT];
    endcase
  end

endmodule
